// ===== src/qru_pkg.sv =====
package qru_pkg;

    localparam int COMP_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    localparam int OPCODE_W = 2;
    localparam int NUM_COMP = 4;
    localparam int NUM_ELEM = 9;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PRODUCT    = 2'd0,
        OP_MATRIX     = 2'd1,
        OP_INV_MATRIX = 2'd2
    } opcode_t;

endpackage

// ===== src/qru_item_if.sv =====
interface qru_item_if #(
    parameter int COMP_WIDTH = qru_pkg::COMP_WIDTH_DEF
);
    logic                            valid;
    logic                            ready;
    logic [qru_pkg::OPCODE_W-1:0]    opcode;
    logic signed [COMP_WIDTH-1:0]    first_q0;
    logic signed [COMP_WIDTH-1:0]    first_q1;
    logic signed [COMP_WIDTH-1:0]    first_q2;
    logic signed [COMP_WIDTH-1:0]    first_q3;
    logic signed [COMP_WIDTH-1:0]    second_q0;
    logic signed [COMP_WIDTH-1:0]    second_q1;
    logic signed [COMP_WIDTH-1:0]    second_q2;
    logic signed [COMP_WIDTH-1:0]    second_q3;

    modport source (
        output valid, opcode, first_q0, first_q1, first_q2, first_q3,
               second_q0, second_q1, second_q2, second_q3,
        input  ready
    );

    modport sink (
        input  valid, opcode, first_q0, first_q1, first_q2, first_q3,
               second_q0, second_q1, second_q2, second_q3,
        output ready
    );
endinterface

// ===== src/qru_result_if.sv =====
interface qru_result_if #(
    parameter int COMP_WIDTH = qru_pkg::COMP_WIDTH_DEF
);
    logic                            valid;
    logic                            ready;
    logic signed [COMP_WIDTH-1:0]    elem0;
    logic signed [COMP_WIDTH-1:0]    elem1;
    logic signed [COMP_WIDTH-1:0]    elem2;
    logic signed [COMP_WIDTH-1:0]    elem3;
    logic signed [COMP_WIDTH-1:0]    elem4;
    logic signed [COMP_WIDTH-1:0]    elem5;
    logic signed [COMP_WIDTH-1:0]    elem6;
    logic signed [COMP_WIDTH-1:0]    elem7;
    logic signed [COMP_WIDTH-1:0]    elem8;
    logic                            saturated;

    modport source (
        output valid, elem0, elem1, elem2, elem3, elem4, elem5, elem6, elem7, elem8,
               saturated,
        input  ready
    );

    modport sink (
        input  valid, elem0, elem1, elem2, elem3, elem4, elem5, elem6, elem7, elem8,
               saturated,
        output ready
    );
endinterface

// ===== src/quaternion_rotation_unit_core.sv =====
// quaternion rotation unit: quaternion product and quaternion-to-matrix
// item channel (sink): opcode plus two signed quaternions, x y z then scalar
//   opcode product: second times first in elem0..elem3, elem4..elem8 zero
//   opcode matrix / inverse matrix: row-major 3x3 of the first quaternion,
//   or its transpose; the second quaternion is ignored
//   the unused opcode gives all zeros
// result channel (source): elem0..elem8 and saturated, set when any
//   element was clipped to the field range after rounding
// three register stages: input, products, rounded result; a result is
//   valid once its request has passed through all three in that order
// throughput is one request per cycle while results are taken, set by
//   the 16 parallel multipliers in the product stage; nothing is carried
//   from one request to the next; when the receiver stalls, the result
//   register holds and each stage keeps taking data while it or the one
//   after it has room, so up to three requests are held before ready drops
// reset clears only the stage valid flags; the block is usable once rst_n
//   rises
module quaternion_rotation_unit_core #(
    parameter int COMP_WIDTH = qru_pkg::COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = qru_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    qru_item_if.sink          item,
    qru_result_if.source      result
);
    import qru_pkg::*;

    logic                           valid_reg;
    logic [OPCODE_W-1:0]            opcode_reg;
    logic signed [COMP_WIDTH-1:0]   first_reg  [NUM_COMP];
    logic signed [COMP_WIDTH-1:0]   second_reg [NUM_COMP];
    logic                           in_ready;
    logic                           load;

    logic                           mul_ready;
    logic                           mul_valid;
    logic [OPCODE_W-1:0]            mul_opcode;
    logic signed [2*COMP_WIDTH-1:0] prod [NUM_COMP][NUM_COMP];

    logic                           sum_ready;
    logic signed [COMP_WIDTH-1:0]   elem [NUM_ELEM];

    assign in_ready   = !valid_reg || mul_ready;
    assign item.ready = in_ready;
    assign load       = item.valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            opcode_reg    <= item.opcode;
            first_reg[0]  <= item.first_q0;
            first_reg[1]  <= item.first_q1;
            first_reg[2]  <= item.first_q2;
            first_reg[3]  <= item.first_q3;
            second_reg[0] <= item.second_q0;
            second_reg[1] <= item.second_q1;
            second_reg[2] <= item.second_q2;
            second_reg[3] <= item.second_q3;
        end
    end

    qru_mul_stage #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (valid_reg),
        .in_ready   (mul_ready),
        .in_opcode  (opcode_reg),
        .first_q    (first_reg),
        .second_q   (second_reg),
        .out_valid  (mul_valid),
        .out_ready  (sum_ready),
        .out_opcode (mul_opcode),
        .prod       (prod)
    );

    qru_sum_stage #(
        .COMP_WIDTH (COMP_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_sum (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (mul_valid),
        .in_ready   (sum_ready),
        .opcode     (mul_opcode),
        .prod       (prod),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .elem       (elem),
        .saturated  (result.saturated)
    );

    assign result.elem0 = elem[0];
    assign result.elem1 = elem[1];
    assign result.elem2 = elem[2];
    assign result.elem3 = elem[3];
    assign result.elem4 = elem[4];
    assign result.elem5 = elem[5];
    assign result.elem6 = elem[6];
    assign result.elem7 = elem[7];
    assign result.elem8 = elem[8];

endmodule

// ===== src/qru_mul_stage.sv =====
module qru_mul_stage #(
    parameter int COMP_WIDTH = qru_pkg::COMP_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [qru_pkg::OPCODE_W-1:0]      in_opcode,
    input  logic signed [COMP_WIDTH-1:0]      first_q  [qru_pkg::NUM_COMP],
    input  logic signed [COMP_WIDTH-1:0]      second_q [qru_pkg::NUM_COMP],
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [qru_pkg::OPCODE_W-1:0]      out_opcode,
    output logic signed [2*COMP_WIDTH-1:0]    prod [qru_pkg::NUM_COMP][qru_pkg::NUM_COMP]
);
    import qru_pkg::*;

    logic                           valid_reg;
    logic                           valid_next;
    logic [OPCODE_W-1:0]            opcode_reg;
    logic signed [COMP_WIDTH-1:0]   lhs [NUM_COMP];
    logic signed [2*COMP_WIDTH-1:0] prod_reg  [NUM_COMP][NUM_COMP];
    logic signed [2*COMP_WIDTH-1:0] prod_next [NUM_COMP][NUM_COMP];
    logic                           load;

    assign in_ready   = !valid_reg || out_ready;
    assign load       = in_valid && in_ready;
    assign valid_next = in_valid || (valid_reg && !out_ready);

    // the matrix needs every pairwise product of the first quaternion,
    // the product every second-by-first pair: one array of 16 serves both
    always_comb
    begin
        for (int j = 0; j < NUM_COMP; j++)
        begin
            lhs[j] = (in_opcode == OP_PRODUCT) ? second_q[j] : first_q[j];
        end
        for (int j = 0; j < NUM_COMP; j++)
        begin
            for (int k = 0; k < NUM_COMP; k++)
            begin
                prod_next[j][k] = (2*COMP_WIDTH)'(lhs[j]) * (2*COMP_WIDTH)'(first_q[k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            opcode_reg <= in_opcode;
            prod_reg   <= prod_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_opcode = opcode_reg;
    assign prod       = prod_reg;

endmodule

// ===== src/qru_sum_stage.sv =====
module qru_sum_stage #(
    parameter int COMP_WIDTH = qru_pkg::COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = qru_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [qru_pkg::OPCODE_W-1:0]      opcode,
    input  logic signed [2*COMP_WIDTH-1:0]    prod [qru_pkg::NUM_COMP][qru_pkg::NUM_COMP],
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [COMP_WIDTH-1:0]      elem [qru_pkg::NUM_ELEM],
    output logic                              saturated
);
    import qru_pkg::*;

    localparam int ACC_W = (2*COMP_WIDTH + 3 > FRAC_BITS + 2) ? 2*COMP_WIDTH + 3
                                                             : FRAC_BITS + 2;
    localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam int HEAD_W = ACC_W - COMP_WIDTH + 1;

    logic signed [ACC_W-1:0]      ext [NUM_COMP][NUM_COMP];
    logic signed [ACC_W-1:0]      acc [NUM_ELEM];
    logic signed [ACC_W-1:0]      rnd [NUM_ELEM];
    logic signed [ACC_W-1:0]      skew_cd;
    logic signed [ACC_W-1:0]      skew_bd;
    logic signed [ACC_W-1:0]      skew_ad;
    logic [HEAD_W-1:0]            head;
    logic signed [COMP_WIDTH-1:0] elem_next [NUM_ELEM];
    logic                         sat_next;
    logic                         valid_reg;
    logic signed [COMP_WIDTH-1:0] elem_reg [NUM_ELEM];
    logic                         sat_reg;
    logic                         load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        for (int j = 0; j < NUM_COMP; j++)
        begin
            for (int k = 0; k < NUM_COMP; k++)
            begin
                ext[j][k] = ACC_W'(prod[j][k]);
            end
        end

        // skew part flips sign for the inverse rotation
        skew_cd = (opcode == OP_MATRIX) ? ext[2][3] : -ext[2][3];
        skew_bd = (opcode == OP_MATRIX) ? ext[1][3] : -ext[1][3];
        skew_ad = (opcode == OP_MATRIX) ? ext[0][3] : -ext[0][3];

        for (int e = 0; e < NUM_ELEM; e++)
        begin
            acc[e] = '0;
        end

        case (opcode)
            OP_PRODUCT:
            begin
                acc[0] = ext[0][3] + ext[3][0] + ext[1][2] - ext[2][1];
                acc[1] = ext[1][3] + ext[3][1] + ext[2][0] - ext[0][2];
                acc[2] = ext[2][3] + ext[3][2] + ext[0][1] - ext[1][0];
                acc[3] = ext[3][3] - ext[2][2] - ext[1][1] - ext[0][0];
            end
            OP_MATRIX, OP_INV_MATRIX:
            begin
                acc[0] = ext[0][0] - ext[1][1] - ext[2][2] + ext[3][3];
                acc[4] = ext[1][1] - ext[0][0] - ext[2][2] + ext[3][3];
                acc[8] = ext[2][2] - ext[0][0] - ext[1][1] + ext[3][3];
                acc[1] = (ext[0][1] + skew_cd) <<< 1;
                acc[3] = (ext[0][1] - skew_cd) <<< 1;
                acc[2] = (ext[0][2] - skew_bd) <<< 1;
                acc[6] = (ext[0][2] + skew_bd) <<< 1;
                acc[5] = (ext[1][2] + skew_ad) <<< 1;
                acc[7] = (ext[1][2] - skew_ad) <<< 1;
            end
            default:
            begin
            end
        endcase

        // round half up, then clip where the dropped head is not a sign run
        sat_next = 1'b0;
        head     = '0;
        for (int e = 0; e < NUM_ELEM; e++)
        begin
            rnd[e] = (acc[e] + ROUND_C) >>> FRAC_BITS;
            head   = rnd[e][ACC_W-1:COMP_WIDTH-1];
            if ((&head) || !(|head))
            begin
                elem_next[e] = rnd[e][COMP_WIDTH-1:0];
            end
            else
            begin
                sat_next     = 1'b1;
                elem_next[e] = rnd[e][ACC_W-1] ? {1'b1, {(COMP_WIDTH-1){1'b0}}}
                                               : {1'b0, {(COMP_WIDTH-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            elem_reg <= elem_next;
            sat_reg  <= sat_next;
        end
    end

    assign out_valid = valid_reg;
    assign elem      = elem_reg;
    assign saturated = sat_reg;

endmodule
